// ----- sv/rise_rate_bucket_history_assert.svh -----
// Assertion macros for the rise rate bucket history block.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef RISE_RATE_BUCKET_HISTORY_ASSERT_SVH
`define RISE_RATE_BUCKET_HISTORY_ASSERT_SVH

// property holds at every edge outside reset
`define RRBH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition never holds outside reset
`define RRBH_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/rrbh_pkg.sv -----
// Shared types and constants for the rise rate bucket history block.
// No dependencies.
package rrbh_pkg;

    localparam int LEVEL_W   = 16;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = 5;
    localparam int PERIOD_W  = 22;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 22;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX        = 16'hFFFF;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET     = 22'd60000;
    localparam logic [LEVEL_W-1:0]   PEAK_FLOOR_RESET = 16'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_PERIOD_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR       = 1'd1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  now_ms;
        logic [LEVEL_W-1:0] level;
        logic [IDX_W-1:0]   bucket_index;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] bucket_value;
        logic [LEVEL_W-1:0] peak_value;
        logic [TIME_W-1:0]  change_count;
        logic               is_primed;
    } out_word_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLOSE,
        ST_SETTLE
    } state_t;

endpackage

// ----- sv/rrbh_cell.sv -----
// One history bucket of the cell row, with its slice of the peak and select ripples.
// Depends on rrbh_pkg.
module rrbh_cell #(
    parameter int INDEX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rrbh_pkg::cell_ctl_t              ctl,
    input  logic [rrbh_pkg::IDX_W-1:0]       sel_index,
    input  logic [rrbh_pkg::LEVEL_W-1:0]     value_in,
    input  logic [rrbh_pkg::LEVEL_W-1:0]     peak_in,
    input  logic [rrbh_pkg::LEVEL_W-1:0]     sel_in,
    output logic [rrbh_pkg::LEVEL_W-1:0]     value_out,
    output logic [rrbh_pkg::LEVEL_W-1:0]     peak_out,
    output logic [rrbh_pkg::LEVEL_W-1:0]     sel_out
);
    import rrbh_pkg::*;

    logic [LEVEL_W-1:0] value_reg, value_next;
    logic [LEVEL_W-1:0] peak_reg, peak_next;
    logic [LEVEL_W-1:0] sel_reg, sel_next;
    logic               hit;

    assign hit = (int'(sel_index) == INDEX);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.clear)
        begin
            value_next = '0;
        end
        else if (ctl.shift)
        begin
            value_next = value_in;
        end
        // running maximum from the newer side toward the oldest cell
        peak_next = (value_reg > peak_in) ? value_reg : peak_in;
        sel_next  = hit ? value_reg : sel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            peak_reg  <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            peak_reg  <= peak_next;
            sel_reg   <= sel_next;
        end
    end

    assign value_out = value_reg;
    assign peak_out  = peak_reg;
    assign sel_out   = sel_reg;

endmodule

// ----- sv/rise_rate_bucket_history.sv -----
// Rise rate bucket history: a row of NUM_BUCKETS bucket cells and the sample sequencer.
// A read, or the first sample, goes straight to the settle state; a primed sample is
// checked first and then either clears the whole history or runs the close loop
// before it settles. Settling lets the peak and bucket-select values ripple one
// cell per cycle along the row, and the close loop shifts the row once per cycle.
// A new word is accepted the cycle after the previous result is loaded into
// the output register, which holds it until taken.
module rise_rate_bucket_history #(
    parameter int NUM_BUCKETS = 30
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rrbh_pkg::in_word_t                req_word,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rrbh_pkg::out_word_t               rsp_word,
    input  logic                              cfg_we,
    input  logic [rrbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrbh_pkg::CFG_W-1:0]        cfg_data
);
    import rrbh_pkg::*;

    `include "rise_rate_bucket_history_assert.svh"

    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int SPAN_W = PERIOD_W + $clog2(NUM_BUCKETS + 1);
    localparam logic [CNT_W-1:0] SETTLE_LEN = CNT_W'(NUM_BUCKETS);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [LEVEL_W-1:0]   lvl_reg, lvl_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 op_reg, op_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [PERIOD_W-1:0]  period_reg;
    logic [LEVEL_W-1:0]   floor_reg;
    logic [LEVEL_W-1:0]   open_sum_reg, open_sum_next;
    logic [TIME_W-1:0]    open_start_reg, open_start_next;
    logic [LEVEL_W-1:0]   prev_level_reg, prev_level_next;
    logic                 primed_reg, primed_next;
    logic [TIME_W-1:0]    rev_reg, rev_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    out_word_t            rsp_reg, rsp_next;
    logic                 rsp_load;
    cell_ctl_t            cell_ctl;

    logic [LEVEL_W:0]     sum_w;
    logic [TIME_W-1:0]    gap_w;
    logic [LEVEL_W-1:0]   peak_w;

    logic [LEVEL_W-1:0]   hist_link [NUM_BUCKETS+1];
    logic [LEVEL_W-1:0]   peak_link [NUM_BUCKETS+1];
    logic [LEVEL_W-1:0]   sel_link  [NUM_BUCKETS+1];

    // newest entry comes from the open accumulator; ripples start from zero
    assign hist_link[NUM_BUCKETS] = open_sum_reg;
    assign peak_link[NUM_BUCKETS] = '0;
    assign sel_link[NUM_BUCKETS]  = '0;

    for (genvar i = 0; i < NUM_BUCKETS; i++)
    begin : g_cell
        rrbh_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .sel_index (idx_reg),
            .value_in  (hist_link[i+1]),
            .peak_in   (peak_link[i+1]),
            .sel_in    (sel_link[i+1]),
            .value_out (hist_link[i]),
            .peak_out  (peak_link[i]),
            .sel_out   (sel_link[i])
        );
    end

    assign peak_w = (peak_link[0] > floor_reg) ? peak_link[0] : floor_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        span_next       = span_reg;
        open_sum_next   = open_sum_reg;
        open_start_next = open_start_reg;
        prev_level_next = prev_level_reg;
        primed_next     = primed_reg;
        rev_next        = rev_reg;
        cell_ctl        = '0;
        rsp_load        = 1'b0;
        req_ready       = (state_reg == ST_IDLE);
        sum_w           = {1'b0, open_sum_reg};
        gap_w           = now_reg - open_start_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    now_next  = req_word.now_ms;
                    lvl_next  = req_word.level;
                    idx_next  = req_word.bucket_index;
                    op_next   = req_word.operation;
                    span_next = SPAN_W'(period_reg) * SPAN_W'(NUM_BUCKETS);
                    cnt_next  = '0;
                    if (req_word.operation == OP_SAMPLE && primed_reg)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        if (req_word.operation == OP_SAMPLE)
                        begin
                            // first sample only primes
                            prev_level_next = req_word.level;
                            open_start_next = req_word.now_ms;
                            primed_next     = 1'b1;
                        end
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (lvl_reg > prev_level_reg)
                begin
                    sum_w = {1'b0, open_sum_reg} + {1'b0, lvl_reg - prev_level_reg};
                end
                prev_level_next = lvl_reg;
                if (gap_w >= TIME_W'(span_reg))
                begin
                    // whole history elapsed: drop everything, rise included
                    cell_ctl.clear  = 1'b1;
                    open_sum_next   = '0;
                    open_start_next = now_reg;
                    rev_next        = rev_reg + 1'b1;
                    state_next      = ST_SETTLE;
                end
                else
                begin
                    open_sum_next = sum_w[LEVEL_W] ? LEVEL_MAX : sum_w[LEVEL_W-1:0];
                    state_next    = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (gap_w >= TIME_W'(period_reg))
                begin
                    cell_ctl.shift  = 1'b1;
                    open_sum_next   = '0;
                    open_start_next = open_start_reg + TIME_W'(period_reg);
                    rev_next        = rev_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                if (cnt_reg == SETTLE_LEN)
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.bucket_value  = (op_reg == OP_READ) ? sel_link[0]
                                                         : hist_link[NUM_BUCKETS-1];
            rsp_next.peak_value    = peak_w;
            rsp_next.change_count  = rev_reg;
            rsp_next.is_primed     = primed_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            open_sum_reg   <= '0;
            open_start_reg <= '0;
            prev_level_reg <= '0;
            primed_reg     <= 1'b0;
            rev_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            open_sum_reg   <= open_sum_next;
            open_start_reg <= open_start_next;
            prev_level_reg <= prev_level_next;
            primed_reg     <= primed_next;
            rev_reg        <= rev_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        span_reg <= span_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            floor_reg  <= PEAK_FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUCKET_PERIOD_MS: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_PEAK_FLOOR:       floor_reg  <= cfg_data[LEVEL_W-1:0];
                default:              ;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    `RRBH_NEVER(a_shift_clear_excl, cell_ctl.shift && cell_ctl.clear, "shift and clear together")
    `RRBH_ASSERT(a_rev_only_on_change,
                 !(cell_ctl.shift || cell_ctl.clear) |=> $stable(rev_reg),
                 "change count moved without a close or clear")
    `RRBH_ASSERT(a_settle_quiet,
                 state_reg == ST_SETTLE |=> $stable(rev_reg) && $stable(open_start_reg),
                 "state changed while settling")
    `RRBH_ASSERT(a_load_settled,
                 rsp_load |-> state_reg == ST_SETTLE && cnt_reg == SETTLE_LEN,
                 "result loaded before the row settled")

endmodule

// ----- sim/testbench.sv -----
// Testbench for rise_rate_bucket_history: directed and random sample and read words.
// Results are predicted by a scoreboard class and checked field by field.
// Depends on rrbh_pkg and the rise_rate_bucket_history RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbh_pkg::*;

    localparam int NB = 30;

    class bucket_board;
        logic [LEVEL_W-1:0]  hist [NB];
        logic [LEVEL_W-1:0]  open_sum;
        logic [TIME_W-1:0]   open_start;
        logic [LEVEL_W-1:0]  last_level;
        bit                  primed;
        logic [TIME_W-1:0]   changes;
        logic [PERIOD_W-1:0] period;
        logic [LEVEL_W-1:0]  floor_val;
        out_word_t           pending_results [$];
        int                  failures;

        function new();
            foreach (hist[i]) hist[i] = '0;
            open_sum   = '0;
            open_start = '0;
            last_level = '0;
            primed     = 1'b0;
            changes    = '0;
            period     = PERIOD_RESET;
            floor_val  = PEAK_FLOOR_RESET;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_BUCKET_PERIOD_MS)
                period = data[PERIOD_W-1:0];
            else if (idx == CFG_PEAK_FLOOR)
                floor_val = data[LEVEL_W-1:0];
        endfunction

        // Advance the history for one accepted word and queue its result.
        function void note_input(in_word_t w);
            logic [16:0]        sum;
            logic [TIME_W-1:0]  gap;
            longint unsigned    span;
            int                 closes;
            logic [LEVEL_W-1:0] value;
            logic [LEVEL_W-1:0] peak;
            out_word_t          r;
            if (w.operation == OP_SAMPLE) begin
                if (!primed) begin
                    last_level = w.level;
                    open_start = w.now_ms;
                    primed     = 1'b1;
                end else begin
                    if (w.level > last_level) begin
                        sum = {1'b0, open_sum} + {1'b0, w.level - last_level};
                        open_sum = sum[16] ? LEVEL_MAX : sum[LEVEL_W-1:0];
                    end
                    last_level = w.level;
                    gap  = w.now_ms - open_start;
                    span = longint'(period) * NB;
                    if (longint'(gap) >= span) begin
                        foreach (hist[i]) hist[i] = '0;
                        open_sum   = '0;
                        open_start = w.now_ms;
                        changes++;
                    end else begin
                        closes = 0;
                        while (closes < NB && TIME_W'(w.now_ms - open_start) >= TIME_W'(period)) begin
                            for (int i = 0; i < NB - 1; i++) hist[i] = hist[i + 1];
                            hist[NB - 1] = open_sum;
                            open_sum = '0;
                            changes++;
                            open_start += TIME_W'(period);
                            closes++;
                        end
                    end
                end
                value = hist[NB - 1];
            end else begin
                value = (w.bucket_index < NB) ? hist[w.bucket_index] : '0;
            end
            peak = floor_val;
            foreach (hist[i]) if (hist[i] > peak) peak = hist[i];
            r.bucket_value = value;
            r.peak_value   = peak;
            r.change_count = changes;
            r.is_primed    = primed;
            pending_results.push_back(r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.bucket_value !== want.bucket_value) begin
                $error("bucket_value: expected %0d, got %0d", want.bucket_value, got.bucket_value);
                failures++;
            end
            if (got.peak_value !== want.peak_value) begin
                $error("peak_value: expected %0d, got %0d", want.peak_value, got.peak_value);
                failures++;
            end
            if (got.change_count !== want.change_count) begin
                $error("change_count: expected %0d, got %0d", want.change_count, got.change_count);
                failures++;
            end
            if (got.is_primed !== want.is_primed) begin
                $error("is_primed: expected %0d, got %0d", want.is_primed, got.is_primed);
                failures++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    in_word_t             req_word = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    out_word_t            rsp_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    bucket_board          board;
    bit                   calm = 1'b0;
    logic [TIME_W-1:0]    stamp = '0;
    logic [LEVEL_W-1:0]   walk_level = '0;

    rise_rate_bucket_history #(.NUM_BUCKETS(NB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_word(rsp_word);
    end

    function automatic in_word_t sample_word(logic [TIME_W-1:0] now, logic [LEVEL_W-1:0] lvl);
        in_word_t w;
        w.operation    = OP_SAMPLE;
        w.now_ms       = now;
        w.level        = lvl;
        w.bucket_index = IDX_W'($urandom);
        return w;
    endfunction

    function automatic in_word_t read_word(logic [IDX_W-1:0] idx);
        in_word_t w;
        w.operation    = OP_READ;
        w.now_ms       = $urandom;
        w.level        = LEVEL_W'($urandom);
        w.bucket_index = idx;
        return w;
    endfunction

    // Step the time stamp so that gaps land inside a bucket, across several
    // buckets, past the whole history, or anywhere in the 32-bit range.
    function automatic logic [TIME_W-1:0] next_stamp();
        int              pick;
        longint unsigned p;
        longint unsigned d;
        pick = $urandom_range(0, 99);
        p    = board.period;
        if (pick < 5)
            d = 0;
        else if (pick < 45)
            d = (p == 0) ? $urandom_range(0, 50) : $urandom_range(0, 32'(p - 1));
        else if (pick < 80)
            d = p * $urandom_range(1, NB - 1) + ((p == 0) ? 0 : $urandom_range(0, 32'(p - 1)));
        else if (pick < 90)
            d = p * NB + $urandom_range(0, 32'(3 * p));
        else
            return $urandom;
        return stamp + TIME_W'(d);
    endfunction

    function automatic logic [LEVEL_W-1:0] next_level();
        int pick;
        int step;
        int lvl;
        pick = $urandom_range(0, 99);
        step = $urandom_range(0, 4000);
        lvl  = walk_level;
        if (pick < 40)
            lvl = (lvl + step > 65535) ? 65535 : lvl + step;
        else if (pick < 60)
            lvl = (lvl < step) ? 0 : lvl - step;
        else if (pick < 80)
            lvl = $urandom_range(0, 65535);
        else if (pick < 90)
            lvl = 0;
        else
            lvl = 65535;
        return LEVEL_W'(lvl);
    endfunction

    task automatic send_word(in_word_t w);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 35) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        board.note_input(w);
        if (w.operation == OP_SAMPLE) begin
            stamp      = w.now_ms;
            walk_level = w.level;
        end
    endtask

    // Drop valid and hold until every predicted word has been taken.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 3)
                wait_drained();
            if ($urandom_range(0, 99) < 30)
                send_word(read_word(IDX_W'($urandom_range(0, 31))));
            else
                send_word(sample_word(next_stamp(), next_level()));
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0]   base;
        logic [PERIOD_W-1:0] per;
        logic [LEVEL_W-1:0]  flo;
        board = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset contents before priming, and an index past the end
        send_word(read_word(5'd0));
        send_word(read_word(5'd31));
        // prime just below the 32-bit wrap, then rise past saturation
        base = 32'hFFFF_FF00;
        send_word(sample_word(base, 16'd100));
        send_word(sample_word(base + 16, 16'hFFFF));
        send_word(sample_word(base + 32, 16'd0));
        send_word(sample_word(base + 48, 16'hFFFF));
        send_word(sample_word(base + 48, 16'hFFFF));
        // one close across the time wrap, then three at once
        send_word(sample_word(base + 60000, 16'd65000));
        send_word(sample_word(base + 240005, 16'd65100));
        send_word(read_word(5'd29));
        send_word(read_word(5'd28));
        send_word(read_word(5'd0));
        send_word(read_word(5'd30));
        // one short of the whole history closes all but one bucket
        send_word(sample_word(base + 240000 + 1800000 - 1, 16'd200));
        send_word(read_word(5'd1));
        // a whole-history gap clears everything
        send_word(sample_word(base + 240000 + 3600000 - 1, 16'd150));
        send_word(read_word(5'd15));
        send_word(sample_word(base + 240000 + 3600000 - 1, 16'd300));
        send_word(sample_word(base + 240000 + 3660000 - 1, 16'd0));
        send_word(read_word(5'd29));
        send_word(read_word(5'd31));

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin per = 22'd1;                       flo = 16'd0;     end
                1: begin per = 22'd0;                       flo = 16'hFFFF;  end
                2: begin per = 22'd3600000;                 flo = 16'd1000;  end
                3: begin per = 22'h3FFFFF;                  flo = 16'($urandom); end
                4: begin per = 22'($urandom_range(2, 300)); flo = 16'($urandom); end
                default: begin
                    per = 22'($urandom_range(1000, 200000));
                    flo = PEAK_FLOOR_RESET;
                end
            endcase
            write_reg(CFG_BUCKET_PERIOD_MS, CFG_W'(per));
            write_reg(CFG_PEAK_FLOOR, CFG_W'(flo));
            calm = (ph == 2);
            run_random(150);
        end
        calm = 1'b0;

        wait_drained();
        repeat (80) @(posedge clk);
        if (board.failures == 0 && board.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rrbh_pkg.sv
sv/rrbh_cell.sv
sv/rise_rate_bucket_history.sv
sim/testbench.sv
